FILE: design/qalu_pkg.sv
// Types, constants and helpers shared by the quaternion ALU.
package qalu_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_PROD  = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_DIV   = 3'd4,
		CMD_CONJ  = 3'd5,
		CMD_NORM  = 3'd6,
		CMD_INV   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	// widths cover the whole FRAC_BITS range
	localparam int NUM_W   = 63;          // |a| * 2^F + D/2
	localparam int DEN_W   = 57;          // largest divisor (squared magnitude)
	localparam int QB      = 33;          // quotient bits below the overflow flag
	localparam int SQ_W    = 33;          // root bits of a 65-bit radicand
	localparam int RAD_W   = 2 * SQ_W;
	localparam int CW      = 67;          // clamp input width
	localparam int TW      = DEN_W + QB;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] a_w;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] factor;
	} qalu_req_t;

	typedef struct packed {
		logic signed [31:0] r_w;
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		status_t            status;
	} qalu_rsp_t;

	typedef struct packed {
		logic div_op;
		logic norm_op;
		logic inv_op;
		logic div_zero;
	} cls_t;

	typedef logic [3:0][31:0] quat_t;   // [0] is w

	typedef struct packed {
		cmd_t        cmd;
		cls_t        cls;
		quat_t       a;
		quat_t       b;
		logic [31:0] f;
	} item_t;

	typedef struct packed {
		item_t            it;
		quat_t            er;
		logic             esat;
		logic             snz;
		logic [DEN_W-1:0] m2;
	} mid_t;

	typedef struct packed {
		logic [31:0] v;
		logic        sat;
	} clamp_t;

	// Hamilton product: b component and negation per result row and term
	localparam logic [1:0] B_IDX [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};
	localparam logic B_NEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0}
	};

	function automatic clamp_t sat_clamp(input logic signed [CW-1:0] v, input logic [5:0] sb);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		clamp_t r;
		hi = $signed((CW'(1) << (sb - 6'd1)) - CW'(1));
		lo = -hi - $signed(CW'(1));
		r.v = v[31:0];
		r.sat = 1'b0;
		if (v > hi) begin
			r.v = hi[31:0];
			r.sat = 1'b1;
		end else if (v < lo) begin
			r.v = lo[31:0];
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: design/qalu_front.sv
// Front end: accepts request transactions and classifies the operation.
module qalu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  qalu_pkg::qalu_req_t req,
	output logic              item_valid,
	input  logic              item_ready,
	output qalu_pkg::item_t   item
);
	import qalu_pkg::*;

	logic  valid_q;
	item_t item_q;
	item_t cls_item;

	always_comb begin
		cls_item.cmd = req.cmd;
		cls_item.a   = {req.a_z, req.a_y, req.a_x, req.a_w};
		cls_item.b   = {req.b_z, req.b_y, req.b_x, req.b_w};
		cls_item.f   = req.factor;
		cls_item.cls = '0;
		case (req.cmd)
			CMD_DIV: begin
				cls_item.cls.div_op   = 1'b1;
				cls_item.cls.div_zero = (req.factor == 32'sd0);
			end
			CMD_NORM: cls_item.cls.norm_op = 1'b1;
			CMD_INV:  cls_item.cls.inv_op  = 1'b1;
			default: ;
		endcase
	end

	assign req_ready  = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_ready) begin
			valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= cls_item;
		end
	end

endmodule

FILE: design/qalu_fifo.sv
// Short queue between the front end and the arithmetic back end.
module qalu_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  qalu_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output qalu_pkg::item_t rd_item
);
	import qalu_pkg::*;

	item_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            push;
	logic            pop;

	assign wr_ready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

endmodule

FILE: design/qalu_back.sv
// Back end: multiplier array, square-root and divider pipelines, result register.
module qalu_back #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qalu_pkg::item_t     in_item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output qalu_pkg::qalu_rsp_t rsp
);
	import qalu_pkg::*;

	localparam int SB   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int NSTG = 5 + SQ_W + 1 + QB + 1;
	localparam logic signed [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

	logic            en;
	logic            pop;
	logic [NSTG-1:0] vld_q;

	assign en        = !vld_q[NSTG-1] || rsp_ready;
	assign in_ready  = en;
	assign pop       = in_valid && en;
	assign rsp_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], pop};
		end
	end

	// multiplier array
	item_t              it_s1, it_s2, it_s3, it_s4;
	logic signed [31:0] mx [4][4];
	logic signed [31:0] my [4][4];
	logic               mn [4][4];
	logic signed [63:0] p_s2 [4][4];
	logic               ng_s2 [4][4];
	logic signed [64:0] tm [4][4];
	logic signed [64:0] ps_s3 [4][2];
	logic signed [65:0] row_s4 [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				mx[r][j] = '0;
				my[r][j] = '0;
				mn[r][j] = 1'b0;
				case (it_s1.cmd)
					CMD_PROD: begin
						mx[r][j] = it_s1.a[j];
						my[r][j] = it_s1.b[B_IDX[r][j]];
						mn[r][j] = B_NEG[r][j];
					end
					CMD_SCALE: begin
						if (j == 0) begin
							mx[r][j] = it_s1.a[r];
							my[r][j] = it_s1.f;
						end
					end
					CMD_NORM, CMD_INV: begin
						if (r == 0) begin
							mx[r][j] = it_s1.a[j];
							my[r][j] = it_s1.a[j];
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				tm[r][j] = ng_s2[r][j] ? -65'(p_s2[r][j]) : 65'(p_s2[r][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= in_item;
			it_s2 <= it_s1;
			it_s3 <= it_s2;
			it_s4 <= it_s3;
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < 4; j++) begin
					p_s2[r][j]  <= mx[r][j] * my[r][j];
					ng_s2[r][j] <= mn[r][j];
				end
				ps_s3[r][0] <= tm[r][0] + tm[r][1];
				ps_s3[r][1] <= tm[r][2] + tm[r][3];
				row_s4[r]   <= 66'(ps_s3[r][0]) + 66'(ps_s3[r][1]);
			end
		end
	end

	// simple results, squared magnitude
	logic signed [CW-1:0] ev [4];
	logic signed [CW-1:0] ax [4];
	logic signed [CW-1:0] bx [4];
	clamp_t               ec [4];
	logic [64:0]          sq_n;
	mid_t                 mid_n;
	mid_t                 mid_s5;
	logic [64:0]          s_s5;

	always_comb begin
		sq_n         = row_s4[0][64:0];
		mid_n.it     = it_s4;
		mid_n.esat   = 1'b0;
		mid_n.snz    = |sq_n;
		mid_n.m2     = DEN_W'(sq_n >> FRAC_BITS) + DEN_W'(sq_n[FRAC_BITS-1]);
		for (int i = 0; i < 4; i++) begin
			ax[i] = CW'($signed(it_s4.a[i]));
			bx[i] = CW'($signed(it_s4.b[i]));
			case (it_s4.cmd)
				CMD_ADD:   ev[i] = ax[i] + bx[i];
				CMD_SUB:   ev[i] = ax[i] - bx[i];
				CMD_CONJ:  ev[i] = (i == 0) ? ax[i] : -ax[i];
				CMD_PROD, CMD_SCALE: ev[i] = (CW'(row_s4[i]) + HALF) >>> FRAC_BITS;
				default:   ev[i] = '0;
			endcase
			ec[i]       = sat_clamp(ev[i], 6'(SB));
			mid_n.er[i] = ec[i].v;
			mid_n.esat  = mid_n.esat | ec[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s5 <= mid_n;
			s_s5   <= sq_n;
		end
	end

	// integer square root, one result bit per stage
	mid_t              sq_mid_q  [SQ_W];
	logic [RAD_W-1:0]  sq_rad_q  [SQ_W];
	logic [SQ_W+1:0]   sq_rem_q  [SQ_W];
	logic [SQ_W-1:0]   sq_root_q [SQ_W];
	mid_t              sq_mid_i  [SQ_W];
	logic [RAD_W-1:0]  sq_rad_i  [SQ_W];
	logic [SQ_W+1:0]   sq_rem_i  [SQ_W];
	logic [SQ_W-1:0]   sq_root_i [SQ_W];
	logic [SQ_W+3:0]   sq_tmp    [SQ_W];
	logic [SQ_W+3:0]   sq_trial  [SQ_W];

	always_comb begin
		sq_mid_i[0]  = mid_s5;
		sq_rad_i[0]  = RAD_W'(s_s5);
		sq_rem_i[0]  = '0;
		sq_root_i[0] = '0;
		for (int k = 1; k < SQ_W; k++) begin
			sq_mid_i[k]  = sq_mid_q[k-1];
			sq_rad_i[k]  = sq_rad_q[k-1];
			sq_rem_i[k]  = sq_rem_q[k-1];
			sq_root_i[k] = sq_root_q[k-1];
		end
		for (int k = 0; k < SQ_W; k++) begin
			sq_tmp[k]   = {sq_rem_i[k], sq_rad_i[k][RAD_W-1-2*k -: 2]};
			sq_trial[k] = (SQ_W+4)'({sq_root_i[k], 2'b01});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_W; k++) begin
				sq_mid_q[k] <= sq_mid_i[k];
				sq_rad_q[k] <= sq_rad_i[k];
				if (sq_tmp[k] >= sq_trial[k]) begin
					sq_rem_q[k]  <= (SQ_W+2)'(sq_tmp[k] - sq_trial[k]);
					sq_root_q[k] <= {sq_root_i[k][SQ_W-2:0], 1'b1};
				end else begin
					sq_rem_q[k]  <= sq_tmp[k][SQ_W+1:0];
					sq_root_q[k] <= {sq_root_i[k][SQ_W-2:0], 1'b0};
				end
			end
		end
	end

	// divider setup
	mid_t               mid_c;
	logic signed [32:0] fs;
	logic signed [32:0] fmag;
	logic [DEN_W-1:0]   den_c;
	logic signed [32:0] nm [4];
	logic signed [32:0] nmag [4];
	logic [NUM_W-1:0]   num_c [4];
	logic               neg_c [4];
	logic               ovf_c [4];
	mid_t               mid_d0;
	logic [DEN_W-1:0]   den_d0;
	logic [NUM_W-1:0]   num_d0 [4];
	logic               neg_d0 [4];
	logic               ovf_d0 [4];

	always_comb begin
		mid_c = sq_mid_q[SQ_W-1];
		fs    = 33'($signed(mid_c.it.f));
		fmag  = fs[32] ? -fs : fs;
		case (mid_c.it.cmd)
			CMD_DIV:  den_c = DEN_W'(fmag);
			CMD_NORM: den_c = DEN_W'(sq_root_q[SQ_W-1]);
			CMD_INV:  den_c = mid_c.m2;
			default:  den_c = '0;
		endcase
		for (int i = 0; i < 4; i++) begin
			nm[i] = 33'($signed(mid_c.it.a[i]));
			if (mid_c.it.cmd == CMD_INV && i != 0) nm[i] = -nm[i];
			nmag[i]  = nm[i][32] ? -nm[i] : nm[i];
			num_c[i] = (NUM_W'(nmag[i]) << FRAC_BITS) + NUM_W'(den_c >> 1);
			ovf_c[i] = (TW+1)'(num_c[i]) >= ((TW+1)'(den_c) << QB);
			neg_c[i] = nm[i][32] ^ (mid_c.it.cmd == CMD_DIV && mid_c.it.f[31]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_d0 <= mid_c;
			den_d0 <= den_c;
			for (int i = 0; i < 4; i++) begin
				num_d0[i] <= num_c[i];
				neg_d0[i] <= neg_c[i];
				ovf_d0[i] <= ovf_c[i];
			end
		end
	end

	// restoring divider, one quotient bit per stage
	mid_t             dv_mid_q [QB];
	logic [DEN_W-1:0] dv_den_q [QB];
	logic [NUM_W-1:0] dv_r_q   [QB][4];
	logic [QB-1:0]    dv_q_q   [QB][4];
	logic             dv_neg_q [QB][4];
	logic             dv_ovf_q [QB][4];
	mid_t             dv_mid_i [QB];
	logic [DEN_W-1:0] dv_den_i [QB];
	logic [NUM_W-1:0] dv_r_i   [QB][4];
	logic [QB-1:0]    dv_q_i   [QB][4];
	logic             dv_neg_i [QB][4];
	logic             dv_ovf_i [QB][4];
	logic [TW-1:0]    dv_trial [QB];
	logic             dv_ge    [QB][4];

	always_comb begin
		dv_mid_i[0] = mid_d0;
		dv_den_i[0] = den_d0;
		for (int i = 0; i < 4; i++) begin
			dv_r_i[0][i]   = num_d0[i];
			dv_q_i[0][i]   = '0;
			dv_neg_i[0][i] = neg_d0[i];
			dv_ovf_i[0][i] = ovf_d0[i];
		end
		for (int k = 1; k < QB; k++) begin
			dv_mid_i[k] = dv_mid_q[k-1];
			dv_den_i[k] = dv_den_q[k-1];
			for (int i = 0; i < 4; i++) begin
				dv_r_i[k][i]   = dv_r_q[k-1][i];
				dv_q_i[k][i]   = dv_q_q[k-1][i];
				dv_neg_i[k][i] = dv_neg_q[k-1][i];
				dv_ovf_i[k][i] = dv_ovf_q[k-1][i];
			end
		end
		for (int k = 0; k < QB; k++) begin
			dv_trial[k] = TW'(dv_den_i[k]) << (QB - 1 - k);
			for (int i = 0; i < 4; i++) begin
				dv_ge[k][i] = TW'(dv_r_i[k][i]) >= dv_trial[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				dv_mid_q[k] <= dv_mid_i[k];
				dv_den_q[k] <= dv_den_i[k];
				for (int i = 0; i < 4; i++) begin
					dv_neg_q[k][i] <= dv_neg_i[k][i];
					dv_ovf_q[k][i] <= dv_ovf_i[k][i];
					dv_r_q[k][i]   <= dv_ge[k][i] ?
						NUM_W'(TW'(dv_r_i[k][i]) - dv_trial[k]) : dv_r_i[k][i];
					dv_q_q[k][i]   <= dv_q_i[k][i] | (QB'(dv_ge[k][i]) << (QB - 1 - k));
				end
			end
		end
	end

	// result selection and saturation
	mid_t                 mid_f;
	logic                 div_type;
	logic                 err;
	logic                 tiny;
	logic                 dsat;
	logic [QB:0]          mg [4];
	logic signed [CW-1:0] dvv [4];
	clamp_t               dc [4];
	quat_t                dr;
	qalu_rsp_t            rsp_n;
	qalu_rsp_t            rsp_q;

	always_comb begin
		mid_f    = dv_mid_q[QB-1];
		div_type = mid_f.it.cls.div_op | mid_f.it.cls.norm_op | mid_f.it.cls.inv_op;
		err      = (mid_f.it.cls.div_op & mid_f.it.cls.div_zero) |
			((mid_f.it.cls.norm_op | mid_f.it.cls.inv_op) & !mid_f.snz);
		tiny     = mid_f.it.cls.inv_op && (mid_f.m2 == '0);
		dsat     = 1'b0;
		for (int i = 0; i < 4; i++) begin
			mg[i] = {dv_ovf_q[QB-1][i], dv_q_q[QB-1][i]};
			if (tiny) mg[i] = (|mid_f.it.a[i]) ? {1'b1, QB'(0)} : '0;
			dvv[i] = CW'(mg[i]);
			if (dv_neg_q[QB-1][i]) dvv[i] = -dvv[i];
			dc[i] = sat_clamp(dvv[i], 6'(SB));
			dr[i] = dc[i].v;
			dsat  = dsat | dc[i].sat;
		end
		if (!div_type) begin
			rsp_n.r_w    = mid_f.er[0];
			rsp_n.r_x    = mid_f.er[1];
			rsp_n.r_y    = mid_f.er[2];
			rsp_n.r_z    = mid_f.er[3];
			rsp_n.status = mid_f.esat ? ST_SAT : ST_OK;
		end else if (err) begin
			rsp_n.r_w    = '0;
			rsp_n.r_x    = '0;
			rsp_n.r_y    = '0;
			rsp_n.r_z    = '0;
			rsp_n.status = ST_ZERO;
		end else begin
			rsp_n.r_w    = dr[0];
			rsp_n.r_x    = dr[1];
			rsp_n.r_y    = dr[2];
			rsp_n.r_z    = dr[3];
			rsp_n.status = dsat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: design/quaternion_alu.sv
// Top level of the quaternion arithmetic unit.
//
//  channel  direction  handshake              transaction
//  req      in         req_valid / req_ready  qalu_req_t: cmd, a, b, factor
//  rsp      out        rsp_valid / rsp_ready  qalu_rsp_t: r, status
//
// One transaction per cycle sustained while rsp is not stalled; the path from req to rsp
// runs through the 33-stage square-root pipeline followed by the 33-stage divider pipeline.
// arst_n clears all valid flags and the queue pointers; data registers are not reset.
// A stalled rsp freezes the back end; the front end and the 4-entry queue keep
// taking requests until the queue fills.
module quaternion_alu #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  qalu_pkg::qalu_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output qalu_pkg::qalu_rsp_t rsp
);
	import qalu_pkg::*;

	localparam int SB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [31:0] SAT_HI = 32'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [31:0] SAT_LO = 32'(-(64'sd1 <<< (SB - 1)));

	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	qalu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	qalu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	qalu_back #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_ZERO |->
			rsp.r_w == 32'sd0 && rsp.r_x == 32'sd0 && rsp.r_y == 32'sd0 && rsp.r_z == 32'sd0)
		else $error("zero status with nonzero result");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_SAT |->
			rsp.r_w == SAT_HI || rsp.r_w == SAT_LO || rsp.r_x == SAT_HI || rsp.r_x == SAT_LO ||
			rsp.r_y == SAT_HI || rsp.r_y == SAT_LO || rsp.r_z == SAT_HI || rsp.r_z == SAT_LO)
		else $error("saturated status without a limit value");

	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !(q_valid && q_ready))
		else $error("back end took a queue entry while the result was stalled");

endmodule

FILE: tb/sv/qalu_checker.sv
// Checker for the quaternion ALU: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module qalu_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  qalu_pkg::qalu_req_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  qalu_pkg::qalu_rsp_t rsp,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	import qalu_pkg::*;

	localparam int FRAC = 16;

	typedef logic signed [127:0] wide_t;

	qalu_rsp_t expected_q[$];
	int        err_cnt = 0;
	int        chk_cnt = 0;

	assign errors  = err_cnt;
	assign pending = expected_q.size();
	assign checked = chk_cnt;

	function automatic logic [31:0] fit32(input wide_t v, inout logic sat);
		if (v > wide_t'(32'sh7fffffff)) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -wide_t'(64'sh80000000)) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// nearest, ties away from zero
	function automatic wide_t div_nearest(input wide_t n, input wide_t d);
		wide_t un;
		wide_t ud;
		wide_t q;
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic wide_t floor_sqrt(input wide_t s);
		wide_t res;
		wide_t t;
		res = 0;
		for (int i = 33; i >= 0; i--) begin
			t = res | (wide_t'(1) << i);
			if (t * t <= s)
				res = t;
		end
		return res;
	endfunction

	function automatic qalu_rsp_t predict_result(input qalu_req_t q);
		wide_t     a[4];
		wide_t     b[4];
		wide_t     v[4];
		wide_t     f;
		wide_t     s;
		wide_t     m;
		wide_t     half;
		logic      sat;
		logic      zero;
		qalu_rsp_t r;
		a[0] = q.a_w; a[1] = q.a_x; a[2] = q.a_y; a[3] = q.a_z;
		b[0] = q.b_w; b[1] = q.b_x; b[2] = q.b_y; b[3] = q.b_z;
		f = q.factor;
		half = wide_t'(1) << (FRAC - 1);
		sat = 1'b0;
		zero = 1'b0;
		s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
		for (int i = 0; i < 4; i++)
			v[i] = 0;
		case (q.cmd)
			CMD_ADD: for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
			CMD_SUB: for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
			CMD_PROD: begin
				v[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
				v[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
				v[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
				v[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
				for (int i = 0; i < 4; i++) v[i] = (v[i] + half) >>> FRAC;
			end
			CMD_SCALE: for (int i = 0; i < 4; i++) v[i] = (a[i] * f + half) >>> FRAC;
			CMD_DIV: begin
				if (f == 0)
					zero = 1'b1;
				else
					for (int i = 0; i < 4; i++) v[i] = div_nearest(a[i] <<< FRAC, f);
			end
			CMD_CONJ: begin
				v[0] = a[0];
				for (int i = 1; i < 4; i++) v[i] = -a[i];
			end
			CMD_NORM: begin
				if (s == 0)
					zero = 1'b1;
				else begin
					m = floor_sqrt(s);
					for (int i = 0; i < 4; i++) v[i] = div_nearest(a[i] <<< FRAC, m);
				end
			end
			default: begin
				if (s == 0)
					zero = 1'b1;
				else begin
					m = (s >>> FRAC) + ((s >>> (FRAC - 1)) & 1);
					for (int i = 0; i < 4; i++) begin
						f = (i == 0) ? a[i] : -a[i];
						if (m == 0)
							v[i] = (f > 0) ? (wide_t'(1) << 40) : (f < 0) ? -(wide_t'(1) << 40) : 0;
						else
							v[i] = div_nearest(f <<< FRAC, m);
					end
				end
			end
		endcase
		r.r_w = fit32(v[0], sat);
		r.r_x = fit32(v[1], sat);
		r.r_y = fit32(v[2], sat);
		r.r_z = fit32(v[3], sat);
		r.status = zero ? ST_ZERO : sat ? ST_SAT : ST_OK;
		if (zero) begin
			r.r_w = '0; r.r_x = '0; r.r_y = '0; r.r_z = '0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		qalu_rsp_t e;
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_q.push_back(predict_result(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response transaction");
					err_cnt++;
				end else begin
					e = expected_q.pop_front();
					chk_cnt++;
					if (rsp.r_w !== e.r_w) begin
						$error("r_w exp %0d got %0d", e.r_w, rsp.r_w);
						err_cnt++;
					end
					if (rsp.r_x !== e.r_x) begin
						$error("r_x exp %0d got %0d", e.r_x, rsp.r_x);
						err_cnt++;
					end
					if (rsp.r_y !== e.r_y) begin
						$error("r_y exp %0d got %0d", e.r_y, rsp.r_y);
						err_cnt++;
					end
					if (rsp.r_z !== e.r_z) begin
						$error("r_z exp %0d got %0d", e.r_z, rsp.r_z);
						err_cnt++;
					end
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status);
						err_cnt++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_quaternion_alu.sv
// Testbench top for the quaternion ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_quaternion_alu;
	import qalu_pkg::*;

	localparam int LIMIT    = 600000;
	localparam int N_RANDOM = 1700;
	localparam int LATENCY  = 74;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	qalu_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	qalu_rsp_t rsp;
	logic      rsp_fire = 1'b0;

	int errors;
	int pending;
	int checked;
	int cycles = 0;
	int tx_max = 8;
	int rx_max = 8;
	int hold_ask = 0;
	int hold_left = 0;
	int stall = 0;
	int op_cnt[8];

	quaternion_alu u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	qalu_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		rsp_fire <= rsp_valid && rsp_ready;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (rsp_fire)
			stall = $urandom_range(0, rx_max);
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			rsp_ready <= 1'b0;
		end else
			rsp_ready <= arst_n;
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 6))
			0: return $urandom();
			1: return $urandom_range(0, 4 << 16) - (2 << 16);
			2: return $urandom_range(0, 400) - 200;
			3: return 32'h7fffffff;
			4: return 32'h80000000;
			5: return 32'h0;
			default: return $urandom_range(0, 64 << 16) - (32 << 16);
		endcase
	endfunction

	function automatic qalu_req_t rand_item();
		qalu_req_t q;
		q.cmd = cmd_t'($urandom_range(0, 7));
		q.a_w = rand_comp(); q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp();
		q.b_w = rand_comp(); q.b_x = rand_comp(); q.b_y = rand_comp(); q.b_z = rand_comp();
		q.factor = rand_comp();
		if ($urandom_range(0, 9) == 0) begin
			q.a_w = '0; q.a_x = '0; q.a_y = '0; q.a_z = '0;
		end
		return q;
	endfunction

	function automatic qalu_req_t mk(input cmd_t c, input logic [31:0] aw, ax, ay, az,
			input logic [31:0] bw, bx, by, bz, f);
		qalu_req_t q;
		q.cmd = c;
		q.a_w = aw; q.a_x = ax; q.a_y = ay; q.a_z = az;
		q.b_w = bw; q.b_x = bx; q.b_y = by; q.b_z = bz;
		q.factor = f;
		return q;
	endfunction

	task automatic send_item(input qalu_req_t q);
		int gap;
		gap = $urandom_range(0, tx_max);
		repeat (gap) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		op_cnt[q.cmd]++;
		#1;
		while (!req_ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending > 0)
			@(negedge clk);
	endtask

	localparam logic [31:0] MX = 32'h7fffffff;
	localparam logic [31:0] MN = 32'h80000000;
	localparam logic [31:0] ONE = 32'h00010000;

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(mk(CMD_ADD, MX, MN, MX, 0, 1, -1, MX, 0, 0));
		send_item(mk(CMD_SUB, MN, MX, 0, 5, 1, -1, MN, -5, 0));
		send_item(mk(CMD_PROD, ONE, 2 * ONE, 3 * ONE, -ONE, ONE, -ONE, ONE, 0, 0));
		send_item(mk(CMD_PROD, MX, MX, MN, MN, MX, MN, MX, MN, 0));
		send_item(mk(CMD_PROD, ONE, ONE, ONE, ONE, 0, ONE, 2 * ONE, 3 * ONE, 0));
		send_item(mk(CMD_SCALE, MX, MN, 3, -3, 0, 0, 0, 0, MN));
		send_item(mk(CMD_SCALE, ONE, -ONE, 1, -1, 0, 0, 0, 0, 32'h00008000));
		send_item(mk(CMD_DIV, ONE, 2, 3, 4, 0, 0, 0, 0, 0));
		send_item(mk(CMD_DIV, MX, MN, ONE, -ONE, 0, 0, 0, 0, 1));
		send_item(mk(CMD_DIV, 3, -3, ONE, 0, 0, 0, 0, 0, 2 * ONE));
		send_item(mk(CMD_CONJ, MN, MN, MX, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_NORM, 0, 0, 0, 0, MX, MX, MX, MX, MX));
		send_item(mk(CMD_NORM, MN, MN, MN, MN, 0, 0, 0, 0, 0));
		send_item(mk(CMD_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_INV, MN, MN, MN, MN, 0, 0, 0, 0, 0));
		send_item(mk(CMD_INV, 1, -1, 0, 5, 0, 0, 0, 0, 0));
		send_item(mk(CMD_INV, 181, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_INV, 2 * ONE, ONE, 0, -ONE, 0, 0, 0, 0, 0));

		// long receiver stall with a back-to-back sender fills the pipe
		drain();
		tx_max = 0;
		hold_ask = 400;
		for (int i = 0; i < 120; i++)
			send_item(rand_item());
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) begin
				tx_max = (i % 600 == 0) ? 0 : 8;
				rx_max = (i % 400 == 0) ? 0 : 8;
			end
			if (i == N_RANDOM / 2)
				drain();
			send_item(rand_item());
		end

		req_valid <= 1'b0;
		while (pending > 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);

		$display("ops add %0d sub %0d prod %0d scale %0d div %0d conj %0d norm %0d inv %0d",
			op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3],
			op_cnt[4], op_cnt[5], op_cnt[6], op_cnt[7]);
		$display("%0d results compared in %0d cycles, %0d still awaited",
			checked, cycles, pending);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
